// ===== design/lge_pkg.sv =====
// Shared types, constants and helpers for the life grid generation engine.
// No dependencies; imported by every module of the block.
package lge_pkg;

  localparam int MAX_ROWS  = 64;
  localparam int MAX_COLS  = 64;
  localparam int ROW_W     = $clog2(MAX_ROWS);
  localparam int COL_W     = $clog2(MAX_COLS);
  localparam int CFG_W     = 7;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLS = CFG_IDX_W'(1);

  typedef logic [MAX_COLS-1:0] row_word_t;

  typedef enum logic [1:0] {
    MODE_SET     = 2'd0,
    MODE_ADVANCE = 2'd1,
    MODE_READ    = 2'd2,
    MODE_NONE    = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SET_WR,
    ST_RD_OUT,
    ST_GEN_LOAD,
    ST_GEN_ROW
  } state_t;

  typedef struct packed {
    logic             accept;
    logic             rd_en;
    logic             rd_from_in;
    logic [ROW_W-1:0] rd_row;
    logic             wr_set;
    logic             wr_gen;
    logic [ROW_W-1:0] wr_row;
    logic             load_first;
    logic             below_live;
    logic             emit;
    logic             emit_read;
    logic             emit_oor;
  } lge_cmd_t;

  typedef struct packed {
    logic             in_oor;
    logic [CFG_W-1:0] eff_rows;
  } lge_status_t;

  // 0 acts as 1, anything above the maximum acts as the maximum
  function automatic logic [CFG_W-1:0] eff_size(logic [CFG_W-1:0] v,
                                                logic [CFG_W-1:0] maxv);
    logic [CFG_W-1:0] r;
    if (v == '0) begin
      r = CFG_W'(1);
    end else if (v > maxv) begin
      r = maxv;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

// ===== design/lge_ctrl.sv =====
// Controller of the life grid engine: request sequencing and generation sweep.
// Depends on lge_pkg; drives lge_datapath through lge_cmd_t.
module lge_ctrl import lge_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [1:0]  in_mode,
  input  lge_status_t status,
  output logic        busy,
  output lge_cmd_t    cmd
);

  state_t           state_r, state_nxt;
  logic [ROW_W-1:0] sweep_r, sweep_nxt;
  logic [CFG_W-1:0] sweep_p1, sweep_p2;
  mode_t            mode;
  logic             accept;
  logic             last_row;

  assign mode     = mode_t'(in_mode);
  assign busy     = (state_r != ST_IDLE);
  assign accept   = start && (state_r == ST_IDLE);
  assign sweep_p1 = CFG_W'(sweep_r) + CFG_W'(1);
  assign sweep_p2 = CFG_W'(sweep_r) + CFG_W'(2);
  assign last_row = (sweep_p1 == status.eff_rows);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      sweep_r <= '0;
    end else begin
      state_r <= state_nxt;
      sweep_r <= sweep_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    sweep_nxt = sweep_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          priority if (mode == MODE_ADVANCE) begin
            state_nxt = ST_GEN_LOAD;
          end else if (mode == MODE_SET && !status.in_oor) begin
            state_nxt = ST_SET_WR;
          end else if (mode == MODE_READ && !status.in_oor) begin
            state_nxt = ST_RD_OUT;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_SET_WR:   state_nxt = ST_IDLE;
      ST_RD_OUT:   state_nxt = ST_IDLE;
      ST_GEN_LOAD: begin
        state_nxt = ST_GEN_ROW;
        sweep_nxt = '0;
      end
      ST_GEN_ROW: begin
        if (last_row) begin
          state_nxt = ST_IDLE;
          sweep_nxt = '0;
        end else begin
          sweep_nxt = sweep_p1[ROW_W-1:0];
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd        = '0;
    cmd.accept = accept;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          priority if (mode == MODE_ADVANCE) begin
            cmd.rd_en  = 1'b1;
            cmd.rd_row = '0;
          end else if ((mode == MODE_SET || mode == MODE_READ) && !status.in_oor) begin
            cmd.rd_en      = 1'b1;
            cmd.rd_from_in = 1'b1;
          end else begin
            cmd.emit     = 1'b1;
            cmd.emit_oor = (mode != MODE_NONE) && status.in_oor;
          end
        end
      end
      ST_SET_WR: begin
        cmd.wr_set = 1'b1;
        cmd.emit   = 1'b1;
      end
      ST_RD_OUT: begin
        cmd.emit      = 1'b1;
        cmd.emit_read = 1'b1;
      end
      ST_GEN_LOAD: begin
        cmd.load_first = 1'b1;
        cmd.rd_en      = (status.eff_rows > CFG_W'(1));
        cmd.rd_row     = ROW_W'(1);
      end
      ST_GEN_ROW: begin
        cmd.wr_gen     = 1'b1;
        cmd.wr_row     = sweep_r;
        cmd.below_live = (sweep_p1 < status.eff_rows);
        cmd.rd_en      = (sweep_p2 < status.eff_rows);
        cmd.rd_row     = sweep_p2[ROW_W-1:0];
        cmd.emit       = last_row;
      end
      default: cmd = '0;
    endcase
  end

  a_no_rw_collide: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.wr_gen && cmd.rd_en) |-> (cmd.rd_row != cmd.wr_row))
    else $error("sweep reads the row it writes");

  a_sweep_in_grid: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_GEN_ROW) |-> (CFG_W'(sweep_r) < status.eff_rows))
    else $error("sweep row beyond grid");

  a_adv_starts_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && mode == MODE_ADVANCE) |=> (state_r == ST_GEN_LOAD && busy))
    else $error("advance request did not start a sweep");

  a_one_write: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.wr_set && cmd.wr_gen))
    else $error("two writes in one cycle");

endmodule

// ===== design/lge_datapath.sv =====
// Datapath of the life grid engine: grid memory, row window, rule logic, results.
// Depends on lge_pkg; commanded by lge_ctrl.
module lge_datapath import lge_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  lge_cmd_t             cmd,
  input  logic [ROW_W-1:0]     in_cell_row,
  input  logic [COL_W-1:0]     in_cell_col,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  output lge_status_t          status,
  output logic                 out_valid,
  output logic                 out_cell_alive,
  output logic                 out_out_of_range
);

  row_word_t        grid_mem [MAX_ROWS];
  logic [MAX_ROWS-1:0] row_valid_r;
  row_word_t        rdata_r;
  logic             rvalid_r;
  row_word_t        rowdata;
  row_word_t        above_r, cur_r;
  row_word_t        below;
  logic [ROW_W-1:0] row_r;
  logic [COL_W-1:0] col_r;
  logic [CFG_W-1:0] grid_rows_r, grid_cols_r;
  logic [CFG_W-1:0] eff_rows, eff_cols;
  logic             out_valid_r, cell_alive_r, oor_r;
  row_word_t        col_mask, new_row;
  logic [ROW_W-1:0] rd_addr, wr_addr;
  logic             wr_en;
  row_word_t        wr_data;

  assign eff_rows = eff_size(grid_rows_r, CFG_W'(MAX_ROWS));
  assign eff_cols = eff_size(grid_cols_r, CFG_W'(MAX_COLS));

  assign status.eff_rows = eff_rows;
  assign status.in_oor   = (CFG_W'(in_cell_row) >= eff_rows) ||
                           (CFG_W'(in_cell_col) >= eff_cols);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_rows_r <= CFG_W'(MAX_ROWS);
      grid_cols_r <= CFG_W'(MAX_COLS);
    end else if (cfg_we) begin
      if (cfg_index == CFG_GRID_ROWS) begin
        grid_rows_r <= cfg_wdata;
      end else if (cfg_index == CFG_GRID_COLS) begin
        grid_cols_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      row_r <= in_cell_row;
      col_r <= in_cell_col;
    end
  end

  // grid memory, one row word per entry; rows never written read as dead
  assign rd_addr = cmd.rd_from_in ? in_cell_row : cmd.rd_row;
  assign wr_en   = cmd.wr_set || cmd.wr_gen;
  assign wr_addr = cmd.wr_set ? row_r : cmd.wr_row;
  assign wr_data = cmd.wr_set ? (rowdata | (row_word_t'(1) << col_r)) : new_row;
  assign rowdata = rvalid_r ? rdata_r : '0;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      grid_mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rdata_r <= grid_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_valid_r <= '0;
      rvalid_r    <= 1'b0;
    end else begin
      if (wr_en) begin
        row_valid_r[wr_addr] <= 1'b1;
      end
      if (cmd.rd_en) begin
        rvalid_r <= row_valid_r[rd_addr];
      end
    end
  end

  // three-row window: above holds the old row above the one being swept
  assign below = cmd.below_live ? rowdata : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      above_r <= '0;
    end else if (cmd.load_first) begin
      above_r <= '0;
    end else if (cmd.wr_gen) begin
      above_r <= cur_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_first) begin
      cur_r <= rowdata;
    end else if (cmd.wr_gen) begin
      cur_r <= below;
    end
  end

  always_comb begin
    for (int c = 0; c < MAX_COLS; c++) begin
      col_mask[c] = (CFG_W'(c) < eff_cols);
    end
  end

  always_comb begin
    row_word_t  a, m, b;
    row_word_t  a_l, a_r, m_l, m_r, b_l, b_r;
    logic [3:0] cnt;
    a   = above_r & col_mask;
    m   = cur_r & col_mask;
    b   = below & col_mask;
    a_l = a << 1;
    a_r = a >> 1;
    m_l = m << 1;
    m_r = m >> 1;
    b_l = b << 1;
    b_r = b >> 1;
    new_row = cur_r;
    for (int c = 0; c < MAX_COLS; c++) begin
      cnt = 4'(a_l[c]) + 4'(a[c]) + 4'(a_r[c]) + 4'(m_l[c]) + 4'(m_r[c]) +
            4'(b_l[c]) + 4'(b[c]) + 4'(b_r[c]);
      if (col_mask[c]) begin
        new_row[c] = (cnt == 4'd3) || ((cnt == 4'd2) && cur_r[c]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      cell_alive_r <= cmd.emit_read && rowdata[col_r];
      oor_r        <= cmd.emit_oor;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_cell_alive   = cell_alive_r;
  assign out_out_of_range = oor_r;

  a_read_is_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit && cmd.emit_read) |-> !cmd.emit_oor)
    else $error("read result flagged out of range");

  a_write_marks_row: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |=> row_valid_r[$past(wr_addr)])
    else $error("written row not marked valid");

  a_set_keeps_row: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr_set |-> ((wr_data & rowdata) == rowdata))
    else $error("set cleared a live cell");

endmodule

// ===== design/life_grid_generation_engine.sv =====
// Top level of the life grid generation engine.
// Depends on lge_pkg, lge_ctrl and lge_datapath.
//
// Requests are taken when start is high and busy is low. Each one gives one
// result on out_valid, one cycle wide, and the receiver cannot hold it off.
// A set or read request issues its memory read in the accepting cycle, then
// keeps busy high for its write or result state. An advance keeps busy high
// while it loads the first row and then writes one row after another, as the
// sweep goes through the grid memory one row word per cycle on its single
// read port. A set or read outside the grid and the unused mode finish in the
// accepting cycle without raising busy. The result appears the cycle after
// the last busy cycle, or the cycle after acceptance when busy is not raised.
// The grid is all dead after reset with no clearing pass. Configuration
// writes are taken at any time and belong in idle periods.
module life_grid_generation_engine import lge_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [1:0]           in_mode,
  input  logic [ROW_W-1:0]     in_cell_row,
  input  logic [COL_W-1:0]     in_cell_col,
  output logic                 out_valid,
  output logic                 out_cell_alive,
  output logic                 out_out_of_range,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  lge_cmd_t    cmd;
  lge_status_t status;

  assign cfg_ready = 1'b1;

  lge_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_mode (in_mode),
    .status  (status),
    .busy    (busy),
    .cmd     (cmd)
  );

  lge_datapath u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .in_cell_row      (in_cell_row),
    .in_cell_col      (in_cell_col),
    .cfg_we           (cfg_valid && cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .status           (status),
    .out_valid        (out_valid),
    .out_cell_alive   (out_cell_alive),
    .out_out_of_range (out_out_of_range)
  );

endmodule
